[rtl/tlg_pkg.sv]
`default_nettype none

package tlg_pkg;

  // Grid limits
  localparam int unsigned MAX_COLS = 64;
  localparam int unsigned MAX_ROWS = 64;

  // Fixed field widths
  localparam int unsigned COORD_W = 6;   // column / row input fields
  localparam int unsigned SIZE_W  = 7;   // size registers
  localparam int unsigned CFG_IDX_W = 1;

  // Derived storage geometry
  localparam int unsigned COL_IDX_W  = $clog2(MAX_COLS);
  localparam int unsigned ROW_IDX_W  = $clog2(MAX_ROWS);
  localparam int unsigned BANK_DEPTH = 2 ** ROW_IDX_W;
  localparam int unsigned RAM_DEPTH  = 2 * BANK_DEPTH;
  localparam int unsigned RAM_AW     = $clog2(RAM_DEPTH);
  localparam int unsigned STEP_CNT_W = $clog2(MAX_ROWS + 3);

  // Life rule
  localparam int unsigned BIRTH_COUNT   = 3;
  localparam int unsigned SURVIVE_COUNT = 2;

  // Size register reset values
  localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(64);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

  // Operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Result of the coordinate reduction unit
  typedef struct packed {
    logic               done;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } wrap_rsp_t;

endpackage

`default_nettype wire

[rtl/toroidal_life_generation_engine_core.sv]
// Toroidal B3/S23 life engine, row-organized in one dual-port RAM with two banks.
//
// Input channel (in_valid_i / in_stall_o) carries one command per transfer:
// write cell, read cell, next generation or clear grid. Output channel
// (out_valid_o / out_stall_i) returns exactly one cell_state per command:
// the cell for a read, 0 otherwise. Write the size registers via the cfg_we_i /
// cfg_index_i / cfg_wdata_i port only while the engine is idle (not enforced).
//
// Read and write run the six-step coordinate reduction (one remainder bit per
// cycle), then a RAM read-modify-write. Next generation reads one RAM row per
// cycle over the R rows in use, R being the row count after the zero and
// saturation clamp, with the last and first row read again for the wrap.
// One command is processed at a time; the next one is accepted as soon as the
// previous result sits in the output register.
//
// Reset empties the grid at once through per-row valid bits; no sweep.
// A stalled result holds in the output register, and a finished command waits
// for that register to drain before the engine goes idle again.
`default_nettype none

module toroidal_life_generation_engine_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Command channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [1:0]                       operation_i,
  input  wire logic [tlg_pkg::COORD_W-1:0]      column_i,
  input  wire logic [tlg_pkg::COORD_W-1:0]      row_i,
  input  wire logic                             new_state_i,
  // Result channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  cell_state_o,
  // Configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [tlg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [tlg_pkg::SIZE_W-1:0]       cfg_wdata_i
);
  import tlg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,
    S_RMW,
    S_STEP,
    S_FIN
  } state_e;

  state_e                  state_q;
  logic                    active_q;
  logic                    out_valid_q;
  logic                    cell_q;
  logic                    res_q;
  op_e                     op_q;
  logic                    new_state_q;
  logic [SIZE_W-1:0]       cols_q, rows_q;
  logic [SIZE_W-1:0]       cols_eff, rows_eff;
  logic [COL_IDX_W-1:0]    last_col;
  logic [ROW_IDX_W-1:0]    last_row;
  logic [RAM_DEPTH-1:0]    vld_q, vld_d;
  logic                    rvld_q;
  logic                    rvalid_q;
  logic [1:0]              rx_q;
  logic [STEP_CNT_W-1:0]   iss_left_q;
  logic [ROW_IDX_W-1:0]    rd_row_q, wr_row_q;
  logic [MAX_COLS-1:0]     up_q, mid_q;

  logic                    in_acc;
  logic                    out_free;
  logic                    load_out;
  op_e                     op_in;
  wrap_rsp_t               wrap_rsp;
  logic                    wrap_start;
  logic [COL_IDX_W-1:0]    x_idx;
  logic [ROW_IDX_W-1:0]    y_idx;

  logic                    ram_re, ram_we;
  logic [RAM_AW-1:0]       ram_raddr, ram_waddr;
  logic [MAX_COLS-1:0]     ram_wdata, ram_rdata, row_rd;

  // Next state of one row from its upper, own and lower neighbor rows
  function automatic logic [MAX_COLS-1:0] next_row(input logic [MAX_COLS-1:0] up,
                                                   input logic [MAX_COLS-1:0] mid,
                                                   input logic [MAX_COLS-1:0] dn,
                                                   input logic [COL_IDX_W-1:0] last);
    logic [MAX_COLS-1:0] res;
    logic [3:0]          cnt;
    logic                ul, ml, dl, ur, mr, dr;
    for (int x = 0; x < MAX_COLS; x++) begin
      if (x == 0) begin
        ul = up[last];
        ml = mid[last];
        dl = dn[last];
      end else begin
        ul = up[(x + MAX_COLS - 1) % MAX_COLS];
        ml = mid[(x + MAX_COLS - 1) % MAX_COLS];
        dl = dn[(x + MAX_COLS - 1) % MAX_COLS];
      end
      if (COL_IDX_W'(x) == last) begin
        ur = up[0];
        mr = mid[0];
        dr = dn[0];
      end else begin
        ur = up[(x + 1) % MAX_COLS];
        mr = mid[(x + 1) % MAX_COLS];
        dr = dn[(x + 1) % MAX_COLS];
      end
      cnt = 4'(ul) + 4'(up[x]) + 4'(ur) + 4'(ml) + 4'(mr) + 4'(dl) + 4'(dn[x]) + 4'(dr);
      res[x] = (COL_IDX_W'(x) <= last) &&
               ((cnt == 4'(BIRTH_COUNT)) || ((cnt == 4'(SURVIVE_COUNT)) && mid[x]));
    end
    return res;
  endfunction

  // Effective grid size: zero acts as one, large values saturate
  always_comb begin
    if (cols_q == '0) begin
      cols_eff = SIZE_W'(1);
    end else if (int'(cols_q) > MAX_COLS) begin
      cols_eff = SIZE_W'(MAX_COLS);
    end else begin
      cols_eff = cols_q;
    end
    if (rows_q == '0) begin
      rows_eff = SIZE_W'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      rows_eff = SIZE_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_q;
    end
  end

  assign last_col = COL_IDX_W'(cols_eff - SIZE_W'(1));
  assign last_row = ROW_IDX_W'(rows_eff - SIZE_W'(1));

  // Handshakes
  assign in_stall_o   = (state_q != S_IDLE);
  assign in_acc       = in_valid_i && (state_q == S_IDLE);
  assign op_in        = op_e'(operation_i);
  assign out_free     = !out_valid_q || !out_stall_i;
  assign load_out     = (state_q == S_FIN) && out_free;
  assign out_valid_o  = out_valid_q;
  assign cell_state_o = cell_q;

  // Coordinate reduction
  assign wrap_start = in_acc && ((op_in == OP_WRITE) || (op_in == OP_READ));

  tlg_wrap u_wrap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (wrap_start),
    .column_i (column_i),
    .row_i    (row_i),
    .cols_i   (cols_eff),
    .rows_i   (rows_eff),
    .rsp_o    (wrap_rsp)
  );

  assign x_idx = COL_IDX_W'(wrap_rsp.x);
  assign y_idx = ROW_IDX_W'(wrap_rsp.y);

  // Rows never written since reset or clear read as dead
  assign row_rd = ram_rdata & {MAX_COLS{rvld_q}};

  // RAM port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = row_rd;
    unique case (state_q)
      S_WRAP: begin
        if (wrap_rsp.done) begin
          ram_re    = 1'b1;
          ram_raddr = {active_q, y_idx};
        end
      end
      S_RMW: begin
        if (op_q == OP_WRITE) begin
          ram_we           = 1'b1;
          ram_waddr        = {active_q, y_idx};
          ram_wdata[x_idx] = new_state_q;
        end
      end
      S_STEP: begin
        // read source bank, write finished rows into the other bank
        if (iss_left_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = {active_q, rd_row_q};
        end
        if (rvalid_q && (rx_q == 2'd2)) begin
          ram_we    = 1'b1;
          ram_waddr = {~active_q, wr_row_q};
          ram_wdata = next_row(up_q, mid_q, row_rd, last_col);
        end
      end
      S_IDLE, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  tlg_ram #(
    .Width (MAX_COLS),
    .Depth (RAM_DEPTH)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Row valid bits: clear kills both banks, a step empties its target bank
  always_comb begin
    vld_d = vld_q;
    if (in_acc && (op_in == OP_CLEAR)) begin
      vld_d = '0;
    end
    if (in_acc && (op_in == OP_STEP)) begin
      for (int i = 0; i < BANK_DEPTH; i++) begin
        vld_d[{~active_q, ROW_IDX_W'(i)}] = 1'b0;
      end
    end
    if (ram_we) begin
      vld_d[ram_waddr] = 1'b1;
    end
  end

  // Control state machine, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      rvalid_q    <= 1'b0;
      rx_q        <= '0;
      iss_left_q  <= '0;
      vld_q       <= '0;
      cols_q      <= COLS_RESET;
      rows_q      <= ROWS_RESET;
    end else begin
      vld_q <= vld_d;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_COLS: cols_q <= cfg_wdata_i;
          CFG_ROWS: rows_q <= cfg_wdata_i;
        endcase
      end

      // result register: load a finished command, drop on a transfer
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (op_in) inside
              OP_WRITE, OP_READ: state_q <= S_WRAP;
              OP_STEP: begin
                iss_left_q <= STEP_CNT_W'(rows_eff) + STEP_CNT_W'(2);
                rx_q       <= '0;
                state_q    <= S_STEP;
              end
              OP_CLEAR: state_q <= S_FIN;
            endcase
          end
        end
        S_WRAP: begin
          if (wrap_rsp.done) begin
            state_q <= S_RMW;
          end
        end
        S_RMW: begin
          state_q <= S_FIN;
        end
        S_STEP: begin
          rvalid_q <= (iss_left_q != '0);
          if (iss_left_q != '0) begin
            iss_left_q <= iss_left_q - 1'b1;
          end
          if (rvalid_q) begin
            if (rx_q != 2'd2) begin
              rx_q <= rx_q + 1'b1;
            end else if (wr_row_q == last_row) begin
              active_q <= ~active_q;
              state_q  <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q        <= op_in;
      new_state_q <= new_state_i;
      res_q       <= 1'b0;
      rd_row_q    <= last_row;
      wr_row_q    <= '0;
    end
    if (ram_re) begin
      rvld_q <= vld_q[ram_raddr];
    end
    if ((state_q == S_RMW) && (op_q == OP_READ)) begin
      res_q <= row_rd[x_idx];
    end
    // read order: last row, then rows 0 .. last, then row 0 again
    if ((state_q == S_STEP) && (iss_left_q != '0)) begin
      rd_row_q <= (rd_row_q == last_row) ? '0 : rd_row_q + 1'b1;
    end
    if ((state_q == S_STEP) && rvalid_q) begin
      up_q  <= mid_q;
      mid_q <= row_rd;
      if (rx_q == 2'd2) begin
        wr_row_q <= wr_row_q + 1'b1;
      end
    end
    if (load_out) begin
      cell_q <= res_q;
    end
  end

`ifndef SYNTH
  // A generation step never reads and writes the same bank in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) && ram_we && ram_re |-> ram_waddr[RAM_AW-1] != ram_raddr[RAM_AW-1])
    else $error("step reads and writes the same bank");

  // Coordinate results only arrive while a cell access waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrap_rsp.done |-> state_q == S_WRAP)
    else $error("unexpected coordinate result");

  // Step writes stay inside the rows in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) && ram_we |-> wr_row_q <= last_row)
    else $error("step write beyond last row");

  // The bank flips only when a step finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q != $past(active_q) |-> state_q == S_FIN && $past(state_q) == S_STEP)
    else $error("bank swap outside a step");
`endif

endmodule

`default_nettype wire

[rtl/tlg_ram.sv]
`default_nettype none

module tlg_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/tlg_wrap.sv]
`default_nettype none

module tlg_wrap (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [tlg_pkg::COORD_W-1:0]    column_i,
  input  wire logic [tlg_pkg::COORD_W-1:0]    row_i,
  input  wire logic [tlg_pkg::SIZE_W-1:0]     cols_i,
  input  wire logic [tlg_pkg::SIZE_W-1:0]     rows_i,
  output tlg_pkg::wrap_rsp_t                  rsp_o
);
  import tlg_pkg::*;

  localparam int unsigned CNT_W = $clog2(COORD_W + 1);

  logic [CNT_W-1:0]   cnt_q;
  logic               done_q;
  logic [COORD_W-1:0] xs_q, ys_q;   // dividend bits still to shift in
  logic [COORD_W-1:0] xr_q, yr_q;   // partial remainders
  logic [SIZE_W-1:0]  xd_q, yd_q;   // divisors

  logic [COORD_W:0]   xt, yt;
  logic [COORD_W-1:0] xr_d, yr_d;

  // One restoring remainder step per cycle on each coordinate
  always_comb begin
    xt = {xr_q, xs_q[COORD_W-1]};
    yt = {yr_q, ys_q[COORD_W-1]};
    xr_d = (SIZE_W'(xt) >= xd_q) ? COORD_W'(SIZE_W'(xt) - xd_q) : COORD_W'(xt);
    yr_d = (SIZE_W'(yt) >= yd_q) ? COORD_W'(SIZE_W'(yt) - yd_q) : COORD_W'(yt);
  end

  // Step counter and done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(COORD_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xs_q <= column_i;
      ys_q <= row_i;
      xr_q <= '0;
      yr_q <= '0;
      xd_q <= cols_i;
      yd_q <= rows_i;
    end else if (cnt_q != '0) begin
      xs_q <= xs_q << 1;
      ys_q <= ys_q << 1;
      xr_q <= xr_d;
      yr_q <= yr_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.x    = xr_q;
  assign rsp_o.y    = yr_q;

endmodule

`default_nettype wire
